// File: hdl/lzwvwd_pkg.sv
// ---------------------------------------------------------------------------
// lzwvwd_pkg
// Shared constants and types of the variable-width LZW decoder.
// ---------------------------------------------------------------------------
package lzwvwd_pkg;

  localparam int CODE_BITS  = 12;                 // widest code
  localparam int DICT_DEPTH = 1 << CODE_BITS;     // dictionary / stack entries
  localparam int DEPTH_BITS = CODE_BITS + 1;      // stack depth 0..DICT_DEPTH
  localparam int BUF_BITS   = CODE_BITS + 7;      // bit buffer size
  localparam int DICT_W     = CODE_BITS + 8;      // prefix and suffix
  localparam int MAX_DATA   = 63;                 // data results per transaction

  localparam logic [CODE_BITS-1:0] CODE_CLEAR = 12'd256;
  localparam logic [CODE_BITS-1:0] CODE_END   = 12'd257;
  localparam logic [CODE_BITS:0]   CODE_FIRST = 13'd258;
  localparam logic [3:0]           START_W    = 4'd9;

  // result status codes
  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_OK       = 2'd1,
    ST_INVALID  = 2'd2,
    ST_MISMATCH = 2'd3
  } status_t;

  // one result on its way to the output stage
  typedef struct packed {
    logic [7:0] data;
    status_t    status;
  } res_t;

endpackage

// File: hdl/lzwvwd_ram.sv
// ---------------------------------------------------------------------------
// lzwvwd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lzwvwd_ram #(
  parameter int W  = 8,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [1 << AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/lzwvwd_outq.sv
// ---------------------------------------------------------------------------
// lzwvwd_outq
// Result holding stage: one pending result plus the output register, so the
// final result of a transaction can be tagged with tlast.
// ---------------------------------------------------------------------------
module lzwvwd_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lzwvwd_pkg::res_t    push_res,
  input  logic                close,
  output logic                can_push,
  output logic                pend_v,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // out_byte
  output logic [1:0]          m_tuser,   // status
  output logic                m_tlast    // last_of_run
);

  lzwvwd_pkg::res_t pend;
  logic             out_v;

  assign can_push = !pend_v || !out_v;
  assign m_tvalid = out_v;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        out_v <= 1'b0;
      end
      if (push) begin
        pend_v <= 1'b1;
        if (pend_v) begin
          out_v <= 1'b1;
        end
      end else if (close && pend_v) begin
        out_v  <= 1'b1;
        pend_v <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      pend <= push_res;
      if (pend_v) begin
        m_tdata <= pend.data;
        m_tuser <= pend.status;
        m_tlast <= 1'b0;
      end
    end else if (close && pend_v) begin
      m_tdata <= pend.data;
      m_tuser <= pend.status;
      m_tlast <= 1'b1;
    end
  end

endmodule

// File: hdl/lzw_variable_width_decoder_core.sv
// ---------------------------------------------------------------------------
// lzw_variable_width_decoder_core
// LZW decoder for 9 to 12 bit codes packed LSB first, dictionary and
// expansion stack held in synchronous RAMs.
// ---------------------------------------------------------------------------
// Output: one result is held back so tlast can go on the last.
// Decoding: each code reads its prefix chain from the dictionary, pushes the
//   bytes on the expansion stack (plus one for KwKwK) and pops them out.
// Reset: synchronous, active high; the RAMs are not cleared.
module lzw_variable_width_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,   // expected_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // in_byte
  input  logic        s_tuser,       // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // out_byte
  output logic [1:0]  m_tuser,       // status
  output logic        m_tlast        // last_of_run
);

  localparam int CB = lzwvwd_pkg::CODE_BITS;
  localparam int DB = lzwvwd_pkg::DEPTH_BITS;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_DRAIN  = 11'b000_0000_0010,
    S_POP    = 11'b000_0000_0100,
    S_APPEND = 11'b000_0000_1000,
    S_LOOP   = 11'b000_0001_0000,
    S_KWK    = 11'b000_0010_0000,
    S_EXPAND = 11'b000_0100_0000,
    S_WALK   = 11'b000_1000_0000,
    S_ROOT   = 11'b001_0000_0000,
    S_FIN    = 11'b010_0000_0000,
    S_FLUSH  = 11'b100_0000_0000
  } state_t;

  state_t               state;
  logic                 finished;
  logic                 no_more;
  logic [7:0]           in_byte;
  logic                 ret_loop;
  logic [6:0]           n_res;
  logic [DB-1:0]        depth;
  logic [lzwvwd_pkg::BUF_BITS-1:0] bit_buffer;
  logic [4:0]           bit_count;
  logic [3:0]           code_width;
  logic [DB-1:0]        next_free;
  logic [CB-1:0]        last_code;
  logic                 prev_valid;
  logic [7:0]           prev_first;
  logic [CB-1:0]        code;
  logic [CB-1:0]        cur;
  logic [7:0]           root_val;
  logic [31:0]          bytes_out;
  logic [31:0]          exp_len;
  lzwvwd_pkg::status_t  fin_status;

  // memory ports
  logic                 dict_we, dict_re;
  logic [CB-1:0]        dict_waddr, dict_raddr;
  logic [lzwvwd_pkg::DICT_W-1:0] dict_wdata, dict_rdata;
  logic                 stk_we, stk_re;
  logic [CB-1:0]        stk_waddr, stk_raddr;
  logic [7:0]           stk_wdata, stk_rdata;

  // output stage
  logic                 oq_push, oq_close, oq_can, oq_pend;
  lzwvwd_pkg::res_t     oq_res;

  // helpers
  logic                 len_reached, depth_room, drain_go;
  logic [CB:0]          width_mask;
  logic [CB-1:0]        code_now;
  logic [CB-1:0]        walk_next;
  logic                 walk_more;
  logic [DB-1:0]        next_free_inc;

  assign len_reached   = bytes_out >= exp_len;
  assign depth_room    = depth < DB'(lzwvwd_pkg::DICT_DEPTH);
  assign drain_go      = (depth != '0) && (n_res < 7'(lzwvwd_pkg::MAX_DATA)) && !len_reached;
  assign width_mask    = (CB+1)'(({{CB{1'b0}}, 1'b1} << code_width) - 1'b1);
  assign code_now      = bit_buffer[CB-1:0] & width_mask[CB-1:0];
  assign walk_next     = dict_rdata[lzwvwd_pkg::DICT_W-1:8];
  assign walk_more     = (walk_next >= 12'd256) &&
                         ((depth + 1'b1) < DB'(lzwvwd_pkg::DICT_DEPTH));
  assign next_free_inc = next_free + 1'b1;
  assign s_tready      = (state == S_IDLE);

  // dictionary port control
  always_comb begin
    dict_re    = ((state == S_EXPAND) && (cur >= 12'd256) && depth_room) ||
                 ((state == S_WALK) && walk_more);
    dict_raddr = (state == S_WALK) ? walk_next : cur;
    dict_we    = (state == S_ROOT) && prev_valid &&
                 (next_free < DB'(lzwvwd_pkg::DICT_DEPTH));
    dict_waddr = next_free[CB-1:0];
    dict_wdata = {last_code, root_val};
  end

  // stack port control
  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = root_val;
    unique case (state)
      S_KWK: begin
        stk_we    = depth_room;
        stk_wdata = prev_first;
      end
      S_WALK: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rdata[7:0];
      end
      S_ROOT: begin
        stk_we    = depth_room;
        stk_wdata = root_val;
      end
      default: begin
        stk_we    = 1'b0;
      end
    endcase
    stk_waddr = depth[CB-1:0];
    stk_re    = (state == S_DRAIN) && drain_go;
    stk_raddr = CB'(depth - 1'b1);
  end

  // result pushes
  always_comb begin
    oq_push  = 1'b0;
    oq_res   = '{data: stk_rdata, status: lzwvwd_pkg::ST_DATA};
    oq_close = (state == S_FLUSH) && oq_can;
    if (state == S_POP) begin
      oq_push = oq_can;
    end else if (state == S_FIN) begin
      oq_push = oq_can;
      oq_res  = '{data: 8'd0, status: fin_status};
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= '0;
    end else if (cfg_wr_en) begin
      exp_len <= cfg_wr_data;
    end
  end

  // decode sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      finished   <= 1'b0;
      depth      <= '0;
      bit_buffer <= '0;
      bit_count  <= '0;
      code_width <= lzwvwd_pkg::START_W;
      next_free  <= lzwvwd_pkg::CODE_FIRST;
      prev_valid <= 1'b0;
      bytes_out  <= '0;
      n_res      <= '0;
      ret_loop   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            no_more  <= s_tuser;
            in_byte  <= s_tdata;
            n_res    <= '0;
            ret_loop <= 1'b0;
            state    <= finished ? S_FLUSH : S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_go) begin
            depth <= depth - 1'b1;
            state <= S_POP;
          end else begin
            if (len_reached) begin
              depth <= '0;
            end
            state <= ret_loop ? S_LOOP : S_APPEND;
          end
        end
        S_POP: begin
          if (oq_can) begin
            bytes_out <= bytes_out + 1'b1;
            n_res     <= n_res + 1'b1;
            state     <= S_DRAIN;
          end
        end
        S_APPEND: begin
          ret_loop <= 1'b1;
          if (!no_more && (bit_count > 5'(lzwvwd_pkg::BUF_BITS - 8))) begin
            fin_status <= lzwvwd_pkg::ST_INVALID;
            state      <= S_FIN;
          end else begin
            if (!no_more) begin
              bit_buffer <= bit_buffer |
                            (lzwvwd_pkg::BUF_BITS'(in_byte) << bit_count);
              bit_count  <= bit_count + 5'd8;
            end
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (depth != '0) begin
            state <= S_FLUSH;
          end else if (len_reached) begin
            fin_status <= lzwvwd_pkg::ST_OK;
            state      <= S_FIN;
          end else if (bit_count < {1'b0, code_width}) begin
            fin_status <= lzwvwd_pkg::ST_MISMATCH;
            state      <= no_more ? S_FIN : S_FLUSH;
          end else begin
            bit_buffer <= bit_buffer >> code_width;
            bit_count  <= bit_count - {1'b0, code_width};
            code       <= code_now;
            cur        <= code_now;
            priority if (code_now == lzwvwd_pkg::CODE_CLEAR) begin
              code_width <= lzwvwd_pkg::START_W;
              next_free  <= lzwvwd_pkg::CODE_FIRST;
              prev_valid <= 1'b0;
            end else if (code_now == lzwvwd_pkg::CODE_END) begin
              fin_status <= (bytes_out == exp_len) ? lzwvwd_pkg::ST_OK
                                                    : lzwvwd_pkg::ST_MISMATCH;
              state      <= S_FIN;
            end else if ({1'b0, code_now} < next_free) begin
              state <= S_EXPAND;
            end else if (({1'b0, code_now} == next_free) && prev_valid) begin
              state <= S_KWK;
            end else begin
              fin_status <= lzwvwd_pkg::ST_INVALID;
              state      <= S_FIN;
            end
          end
        end
        S_KWK: begin
          if (depth_room) begin
            depth <= depth + 1'b1;
          end
          cur   <= last_code;
          state <= S_EXPAND;
        end
        S_EXPAND: begin
          if ((cur >= 12'd256) && depth_room) begin
            state <= S_WALK;
          end else begin
            root_val <= cur[7:0];
            state    <= S_ROOT;
          end
        end
        S_WALK: begin
          depth <= depth + 1'b1;
          if (!walk_more) begin
            root_val <= walk_next[7:0];
            state    <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (depth_room) begin
            depth <= depth + 1'b1;
          end
          if (dict_we) begin
            next_free <= next_free_inc;
            if ((code_width < 4'(CB)) &&
                (next_free_inc == (DB'(1) << code_width))) begin
              code_width <= code_width + 1'b1;
            end
          end
          last_code  <= code;
          prev_valid <= 1'b1;
          prev_first <= root_val;
          state      <= S_DRAIN;
        end
        S_FIN: begin
          if (oq_can) begin
            finished <= 1'b1;
            depth    <= '0;
            state    <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!oq_pend || oq_can) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // dictionary: prefix in the upper bits, suffix in the low byte
  lzwvwd_ram #(.W(lzwvwd_pkg::DICT_W), .AW(CB)) u_dict (
    .clk   (clk),
    .we    (dict_we),
    .waddr (dict_waddr),
    .wdata (dict_wdata),
    .re    (dict_re),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  // expansion stack
  lzwvwd_ram #(.W(8), .AW(CB)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  lzwvwd_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (oq_push),
    .push_res (oq_res),
    .close    (oq_close),
    .can_push (oq_can),
    .pend_v   (oq_pend),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef SYNTH
  // a new transaction never starts with a result still pending
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !oq_pend)
    else $error("transaction accepted with pending result");

  // stack depth stays within the memory
  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth <= DB'(lzwvwd_pkg::DICT_DEPTH))
    else $error("stack depth overflow");

  // code width stays between 9 and 12
  a_width: assert property (@(posedge clk) disable iff (rst)
    code_width >= lzwvwd_pkg::START_W && code_width <= 4'(CB))
    else $error("code width out of range");

  // once finished, a transaction yields no results
  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && finished |=> !oq_push && !oq_pend)
    else $error("result after finish");
`endif

endmodule
